FILE: hdl/gcdb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gcdb_pkg;

  localparam int AngleFracBits = 16;
  localparam int CordicStages  = 20;
  localparam int SqrtSteps     = 32;

  localparam int LatW   = 24;
  localparam int LonW   = 25;
  localparam int CfgW   = 25;
  localparam int DistW  = 19;
  localparam int BearW  = 25;
  localparam int DegW   = 26;
  localparam int DegProdW = 52;
  localparam int AngW   = 36;
  localparam int XyW    = 34;
  localparam int VecW   = 36;
  localparam int SqrtW  = 64;
  localparam int DistProdW = 54;
  localparam int BearProdW = 64;

  localparam logic CfgObsLat = 1'b0;
  localparam logic CfgObsLon = 1'b1;

  localparam logic signed [DegW-1:0] LatLim = DegW'(90 << AngleFracBits);
  localparam logic signed [DegW-1:0] LonLim = DegW'(180 << AngleFracBits);
  localparam logic signed [DegW-1:0] DegToRad = 26'sd18740330;

  localparam logic signed [AngW-1:0] Q30Pi     = 36'sd3373259426;
  localparam logic signed [AngW-1:0] Q30HalfPi = 36'sd1686629713;
  localparam logic signed [AngW-1:0] Q30TwoPi  = 36'sd6746518852;
  localparam logic [30:0]            Q30One    = 31'd1073741824;
  localparam logic signed [XyW-1:0]  CordicGain = 34'sh26DD3B6A;

  localparam logic [17:0]      DistScale = 18'd203872;
  localparam logic [DistW-1:0] DistMax   = 19'd320240;
  localparam logic [29:0]      RadToDeg  = 30'd961263669;
  localparam int               BearShift = 54 - AngleFracBits;
  localparam logic [BearW-1:0] FullCircle = BearW'(360 << AngleFracBits);

  localparam logic [31:0] AtanTab [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic                   neg;
    logic signed [AngW-1:0] z;
  } rot_in_t;

  function automatic logic signed [DegW-1:0] clamp_deg(
    input logic signed [DegW-1:0] v,
    input logic signed [DegW-1:0] lim
  );
    logic signed [DegW-1:0] r;
    r = v;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    return r;
  endfunction

  // Q30 product, floored.
  function automatic logic signed [XyW-1:0] mulq(
    input logic signed [XyW-1:0] a,
    input logic signed [XyW-1:0] b
  );
    logic signed [2*XyW-1:0] p;
    p = a * b;
    return p[XyW+29:30];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/gcdb_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gcdb_target_if;
  logic                              valid;
  logic                              ready;
  logic signed [gcdb_pkg::LatW-1:0]  target_latitude;
  logic signed [gcdb_pkg::LonW-1:0]  target_longitude;

  modport source (output valid, target_latitude, target_longitude, input ready);
  modport sink   (input valid, target_latitude, target_longitude, output ready);
endinterface

interface gcdb_result_if;
  logic                         valid;
  logic                         ready;
  logic [gcdb_pkg::DistW-1:0]   distance_sixteenths_km;
  logic [gcdb_pkg::BearW-1:0]   bearing_degrees;

  modport source (output valid, distance_sixteenths_km, bearing_degrees, input ready);
  modport sink   (input valid, distance_sixteenths_km, bearing_degrees, output ready);
endinterface

`default_nettype wire

FILE: hdl/great_circle_distance_bearing_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one request per cycle; the whole pipeline advances together and
// freezes only while a result is waiting and the sink is not ready.
// The depth is dominated by two 20-stage CORDIC passes and a 32-step square-root pipeline.
// Reset clears the valid bits and the observer registers; data registers are not reset.

module great_circle_distance_bearing_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_index_i,
  input  wire logic [gcdb_pkg::CfgW-1:0]      cfg_wdata_i,
  gcdb_target_if.sink                         target,
  gcdb_result_if.source                       result
);
  import gcdb_pkg::*;

  localparam int PipeDepth = 2 * CordicStages + SqrtSteps + 9;
  localparam int NumRot = 5;

  logic signed [LatW-1:0] obs_lat_q;
  logic signed [LonW-1:0] obs_lon_q;
  logic [PipeDepth-1:0]   valid_q;
  logic                   adv;

  assign adv          = !valid_q[PipeDepth-1] || result.ready;
  assign target.ready = adv;
  assign result.valid = valid_q[PipeDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs_lat_q <= '0;
      obs_lon_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgObsLat: obs_lat_q <= cfg_wdata_i[LatW-1:0];
        CfgObsLon: obs_lon_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[PipeDepth-2:0], target.valid};
    end
  end

  // Stage 0: clamp and difference.
  logic signed [DegW-1:0] lat1_c, lon1_c, lat2_c, lon2_c;
  logic signed [DegW-1:0] s0_deg_q [4];

  assign lat1_c = clamp_deg(DegW'(obs_lat_q), LatLim);
  assign lon1_c = clamp_deg(DegW'(obs_lon_q), LonLim);
  assign lat2_c = clamp_deg(DegW'(target.target_latitude), LatLim);
  assign lon2_c = clamp_deg(DegW'(target.target_longitude), LonLim);

  // Stage 1: degrees to radians products.
  logic signed [DegProdW-1:0] s1_prod_q [4];

  // Stage 2: rounding and range reduction.
  logic signed [AngW-1:0] rad [4];
  rot_in_t                rot_in_d [NumRot];
  rot_in_t                rot_in_q [NumRot];

  function automatic rot_in_t reduce(input logic signed [AngW-1:0] a);
    rot_in_t r;
    r.z   = a;
    r.neg = 1'b0;
    if (r.z > Q30Pi) r.z = r.z - Q30TwoPi;
    else if (r.z < -Q30Pi) r.z = r.z + Q30TwoPi;
    if (r.z > Q30HalfPi) begin
      r.z   = r.z - Q30Pi;
      r.neg = 1'b1;
    end else if (r.z < -Q30HalfPi) begin
      r.z   = r.z + Q30Pi;
      r.neg = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    logic signed [DegProdW-1:0] rp;
    for (int i = 0; i < 4; i++) begin
      rp     = (s1_prod_q[i] + DegProdW'(1 << (AngleFracBits - 1))) >>> AngleFracBits;
      rad[i] = rp[AngW-1:0];
    end
    rot_in_d[0] = reduce(rad[0]);
    rot_in_d[1] = reduce(rad[1]);
    rot_in_d[2] = reduce(rad[2] >>> 1);
    rot_in_d[3] = reduce(rad[3] >>> 1);
    rot_in_d[4] = reduce(rad[3]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_deg_q[0] <= lat1_c;
      s0_deg_q[1] <= lat2_c;
      s0_deg_q[2] <= lat2_c - lat1_c;
      s0_deg_q[3] <= lon2_c - lon1_c;
      for (int i = 0; i < 4; i++) begin
        s1_prod_q[i] <= s0_deg_q[i] * DegToRad;
      end
      for (int i = 0; i < NumRot; i++) begin
        rot_in_q[i] <= rot_in_d[i];
      end
    end
  end

  // Lanes: observer latitude, target latitude, half latitude step,
  // half longitude step, full longitude step.
  logic signed [XyW-1:0] sin_w [NumRot];
  logic signed [XyW-1:0] cos_w [NumRot];

  for (genvar l = 0; l < NumRot; l++) begin : g_rot
    gcdb_rot_cordic u_rot (
      .clk_i (clk_i),
      .en_i  (adv),
      .in_i  (rot_in_q[l]),
      .sin_o (sin_w[l]),
      .cos_o (cos_w[l])
    );
  end

  // Products, two levels, then the haversine term and the bearing vector.
  logic signed [XyW-1:0] pa_shsh_q, pa_c1c2_q, pa_slsl_q, pa_bx_q, pa_c1s2_q;
  logic signed [XyW-1:0] pa_s1c2_q, pa_cd_q;
  logic signed [XyW-1:0] pb_shsh_q, pb_term_q, pb_bx_q, pb_c1s2_q, pb_s1c2cd_q;
  logic [30:0]           pc_a_q;
  logic signed [XyW-1:0] pc_bx_q;
  logic signed [XyW:0]   pc_by_q;
  logic signed [XyW:0]   a_sum;
  logic [30:0]           a_clamped;

  always_comb begin
    a_sum     = (XyW+1)'(pb_shsh_q) + (XyW+1)'(pb_term_q);
    a_clamped = a_sum[30:0];
    if (a_sum < 0) a_clamped = '0;
    else if (a_sum > signed'({{(XyW-30){1'b0}}, Q30One})) a_clamped = Q30One;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_shsh_q <= mulq(sin_w[2], sin_w[2]);
      pa_c1c2_q <= mulq(cos_w[0], cos_w[1]);
      pa_slsl_q <= mulq(sin_w[3], sin_w[3]);
      pa_bx_q   <= mulq(sin_w[4], cos_w[1]);
      pa_c1s2_q <= mulq(cos_w[0], sin_w[1]);
      pa_s1c2_q <= mulq(sin_w[0], cos_w[1]);
      pa_cd_q   <= cos_w[4];

      pb_shsh_q   <= pa_shsh_q;
      pb_term_q   <= mulq(pa_c1c2_q, pa_slsl_q);
      pb_bx_q     <= pa_bx_q;
      pb_c1s2_q   <= pa_c1s2_q;
      pb_s1c2cd_q <= mulq(pa_s1c2_q, pa_cd_q);

      pc_a_q  <= a_clamped;
      pc_bx_q <= pb_bx_q;
      pc_by_q <= (XyW+1)'(pb_c1s2_q) - (XyW+1)'(pb_s1c2cd_q);
    end
  end

  // Square roots of a and 1-a, one result bit per stage.
  logic [SqrtW-1:0]      sq_v_q [SqrtSteps][2];
  logic [SqrtW-1:0]      sq_r_q [SqrtSteps][2];
  logic signed [XyW-1:0] sq_bx_q [SqrtSteps];
  logic signed [XyW:0]   sq_by_q [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [SqrtW-1:0] Bit = SqrtW'(1) << (62 - 2 * k);
    logic [SqrtW-1:0]      vin [2];
    logic [SqrtW-1:0]      rin [2];
    logic signed [XyW-1:0] bxin;
    logic signed [XyW:0]   byin;

    if (k == 0) begin : g_first
      assign vin[0] = SqrtW'(pc_a_q) << 30;
      assign vin[1] = SqrtW'(Q30One - pc_a_q) << 30;
      assign rin[0] = '0;
      assign rin[1] = '0;
      assign bxin   = pc_bx_q;
      assign byin   = pc_by_q;
    end else begin : g_next
      assign vin[0] = sq_v_q[k-1][0];
      assign vin[1] = sq_v_q[k-1][1];
      assign rin[0] = sq_r_q[k-1][0];
      assign rin[1] = sq_r_q[k-1][1];
      assign bxin   = sq_bx_q[k-1];
      assign byin   = sq_by_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int l = 0; l < 2; l++) begin
          if (vin[l] >= rin[l] + Bit) begin
            sq_v_q[k][l] <= vin[l] - (rin[l] + Bit);
            sq_r_q[k][l] <= (rin[l] >> 1) + Bit;
          end else begin
            sq_v_q[k][l] <= vin[l];
            sq_r_q[k][l] <= rin[l] >> 1;
          end
        end
        sq_bx_q[k] <= bxin;
        sq_by_q[k] <= byin;
      end
    end
  end

  // atan2 setup: lane 0 is the central half-angle, lane 1 the bearing.
  // Vectors on an axis skip the iterations and keep their exact angle.
  logic signed [VecW-1:0] vy [2];
  logic signed [VecW-1:0] vx [2];
  logic signed [VecW-1:0] pre_x_d [2], pre_y_d [2], pre_x_q [2], pre_y_q [2];
  logic signed [AngW-1:0] pre_z_d [2], pre_z_q [2];
  logic                   pre_hold_d [2], pre_hold_q [2];

  assign vy[0] = VecW'(sq_r_q[SqrtSteps-1][0][31:0]);
  assign vx[0] = VecW'(sq_r_q[SqrtSteps-1][1][31:0]);
  assign vy[1] = VecW'(sq_bx_q[SqrtSteps-1]);
  assign vx[1] = VecW'(sq_by_q[SqrtSteps-1]);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      pre_x_d[l]    = vx[l];
      pre_y_d[l]    = vy[l];
      pre_z_d[l]    = '0;
      pre_hold_d[l] = 1'b0;
      if (vy[l] == 0) begin
        pre_hold_d[l] = 1'b1;
        pre_z_d[l]    = (vx[l] >= 0) ? '0 : Q30Pi;
      end else if (vx[l] == 0) begin
        pre_hold_d[l] = 1'b1;
        pre_z_d[l]    = (vy[l] > 0) ? Q30HalfPi : -Q30HalfPi;
      end else if (vx[l] < 0) begin
        pre_x_d[l] = -vx[l];
        pre_y_d[l] = -vy[l];
        pre_z_d[l] = Q30Pi;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        pre_x_q[l]    <= pre_x_d[l];
        pre_y_q[l]    <= pre_y_d[l];
        pre_z_q[l]    <= pre_z_d[l];
        pre_hold_q[l] <= pre_hold_d[l];
      end
    end
  end

  logic signed [AngW-1:0] vz_w [2];

  for (genvar l = 0; l < 2; l++) begin : g_vec
    gcdb_vec_cordic u_vec (
      .clk_i  (clk_i),
      .en_i   (adv),
      .x_i    (pre_x_q[l]),
      .y_i    (pre_y_q[l]),
      .z_i    (pre_z_q[l]),
      .hold_i (pre_hold_q[l]),
      .z_o    (vz_w[l])
    );
  end

  // Scaling to output units.
  logic [AngW-1:0]         t_pos;
  logic signed [AngW-1:0]  ang;
  logic [DistProdW-1:0]    p1_dprod_q;
  logic [BearProdW-1:0]    p1_bprod_q;
  logic [DistProdW-1:0]    dist_full;
  logic [DistW-1:0]        dist_d, dist_q;
  logic [BearProdW-1:0]    deg_full;
  logic [BearW-1:0]        bear_d, bear_q;

  always_comb begin
    t_pos = (vz_w[0] < 0) ? '0 : vz_w[0];
    ang   = vz_w[1];
    if (ang < 0) ang = ang + Q30TwoPi;
    if (ang < 0) ang = '0;
    if (ang >= Q30TwoPi) ang = ang - Q30TwoPi;
    if (ang >= Q30TwoPi) ang = '0;
  end

  always_comb begin
    dist_full = (p1_dprod_q + DistProdW'(1 << 29)) >> 30;
    dist_d    = (dist_full > DistProdW'(DistMax)) ? DistMax : dist_full[DistW-1:0];
    deg_full  = (p1_bprod_q + (BearProdW'(1) << (BearShift - 1))) >> BearShift;
    if (deg_full >= BearProdW'(FullCircle)) deg_full = deg_full - BearProdW'(FullCircle);
    bear_d = deg_full[BearW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_dprod_q <= DistProdW'(t_pos) * DistProdW'(DistScale);
      p1_bprod_q <= BearProdW'(ang[33:0]) * BearProdW'(RadToDeg);
      dist_q     <= dist_d;
      bear_q     <= bear_d;
    end
  end

  assign result.distance_sixteenths_km = dist_q;
  assign result.bearing_degrees        = bear_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result.valid |-> result.distance_sixteenths_km <= DistMax)
    else $error("distance beyond the sphere's half circumference");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result.valid |-> result.bearing_degrees < FullCircle)
    else $error("bearing not wrapped below 360 degrees");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !target.ready |-> result.valid)
    else $error("pipeline stalled with no result waiting");

endmodule

`default_nettype wire

FILE: hdl/gcdb_rot_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module gcdb_rot_cordic (
  input  wire logic                             clk_i,
  input  wire logic                             en_i,
  input  wire gcdb_pkg::rot_in_t                in_i,
  output logic signed [gcdb_pkg::XyW-1:0]       sin_o,
  output logic signed [gcdb_pkg::XyW-1:0]       cos_o
);
  import gcdb_pkg::*;

  logic signed [XyW-1:0]  x_q [CordicStages];
  logic signed [XyW-1:0]  y_q [CordicStages];
  logic signed [AngW-1:0] z_q [CordicStages];
  logic                   neg_q [CordicStages];

  for (genvar k = 0; k < CordicStages; k++) begin : g_stage
    logic signed [XyW-1:0]  xin, yin, xs, ys;
    logic signed [AngW-1:0] zin, at;
    logic                   nin;

    if (k == 0) begin : g_first
      assign xin = CordicGain;
      assign yin = '0;
      assign zin = in_i.z;
      assign nin = in_i.neg;
    end else begin : g_next
      assign xin = x_q[k-1];
      assign yin = y_q[k-1];
      assign zin = z_q[k-1];
      assign nin = neg_q[k-1];
    end

    assign xs = xin >>> k;
    assign ys = yin >>> k;
    assign at = signed'({{(AngW-32){1'b0}}, AtanTab[k]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (zin >= 0) begin
          x_q[k] <= xin - ys;
          y_q[k] <= yin + xs;
          z_q[k] <= zin - at;
        end else begin
          x_q[k] <= xin + ys;
          y_q[k] <= yin - xs;
          z_q[k] <= zin + at;
        end
        neg_q[k] <= nin;
      end
    end
  end

  // A folded angle flips the sign of both results.
  assign sin_o = neg_q[CordicStages-1] ? -y_q[CordicStages-1] : y_q[CordicStages-1];
  assign cos_o = neg_q[CordicStages-1] ? -x_q[CordicStages-1] : x_q[CordicStages-1];

endmodule

`default_nettype wire

FILE: hdl/gcdb_vec_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module gcdb_vec_cordic (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic signed [gcdb_pkg::VecW-1:0]  x_i,
  input  wire logic signed [gcdb_pkg::VecW-1:0]  y_i,
  input  wire logic signed [gcdb_pkg::AngW-1:0]  z_i,
  input  wire logic                              hold_i,
  output logic signed [gcdb_pkg::AngW-1:0]       z_o
);
  import gcdb_pkg::*;

  logic signed [VecW-1:0] x_q [CordicStages];
  logic signed [VecW-1:0] y_q [CordicStages];
  logic signed [AngW-1:0] z_q [CordicStages];
  logic                   hold_q [CordicStages];

  for (genvar k = 0; k < CordicStages; k++) begin : g_stage
    logic signed [VecW-1:0] xin, yin, xs, ys;
    logic signed [AngW-1:0] zin, at;
    logic                   hin;

    if (k == 0) begin : g_first
      assign xin = x_i;
      assign yin = y_i;
      assign zin = z_i;
      assign hin = hold_i;
    end else begin : g_next
      assign xin = x_q[k-1];
      assign yin = y_q[k-1];
      assign zin = z_q[k-1];
      assign hin = hold_q[k-1];
    end

    assign xs = xin >>> k;
    assign ys = yin >>> k;
    assign at = signed'({{(AngW-32){1'b0}}, AtanTab[k]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        hold_q[k] <= hin;
        if (hin) begin
          x_q[k] <= xin;
          y_q[k] <= yin;
          z_q[k] <= zin;
        end else if (yin > 0) begin
          x_q[k] <= xin + ys;
          y_q[k] <= yin - xs;
          z_q[k] <= zin + at;
        end else begin
          x_q[k] <= xin - ys;
          y_q[k] <= yin + xs;
          z_q[k] <= zin - at;
        end
      end
    end
  end

  assign z_o = z_q[CordicStages-1];

endmodule

`default_nettype wire

FILE: tb/gcdb_checker.sv
`timescale 1ns / 1ps

module gcdb_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [gcdb_pkg::CfgW-1:0]   cfg_wdata_i,
  gcdb_target_if                      target,
  gcdb_result_if                      result,
  output int                          fail_count_o,
  output int                          pending_o
);
  import gcdb_pkg::*;

  typedef struct packed {
    logic [DistW-1:0] dist16;
    logic [BearW-1:0] bear;
  } range_bearing_t;

  localparam longint PiQ30     = 64'sd3373259426;
  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam longint TwoPiQ30  = 64'sd6746518852;

  range_bearing_t expected_fixes[$];
  longint observer_lat, observer_lon;

  assign pending_o = expected_fixes.size();

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint deg_to_rad(input longint d);
    return (d * 64'sd18740330 + (64'sd1 <<< (AngleFracBits - 1))) >>> AngleFracBits;
  endfunction

  function automatic void rotate_sincos(input longint ang, output longint s,
                                        output longint c);
    longint x, y, nx, z;
    bit flip;
    x = 64'sh26DD3B6A;
    y = 0;
    z = ang;
    flip = 0;
    if (z > PiQ30) z -= TwoPiQ30;
    if (z > PiQ30) z -= TwoPiQ30;
    if (z < -PiQ30) z += TwoPiQ30;
    if (z < -PiQ30) z += TwoPiQ30;
    if (z > HalfPiQ30) begin
      z -= PiQ30;
      flip = 1;
    end else if (z < -HalfPiQ30) begin
      z += PiQ30;
      flip = 1;
    end
    for (int i = 0; i < CordicStages; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= longint'(AtanTab[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += longint'(AtanTab[i]);
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint vector_atan2(input longint yi, input longint xi);
    longint x, y, z, nx;
    x = xi;
    y = yi;
    z = 0;
    if (y == 0) return (x >= 0) ? 0 : PiQ30;
    if (x == 0) return (y > 0) ? HalfPiQ30 : -HalfPiQ30;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = PiQ30;
    end
    for (int i = 0; i < CordicStages; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += longint'(AtanTab[i]);
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= longint'(AtanTab[i]);
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic longint unsigned digit_sqrt(input longint unsigned v);
    longint unsigned r, b, rem;
    rem = v;
    r = 0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= r + b) begin
        rem -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic range_bearing_t predict_fix(input logic signed [LatW-1:0] tlat,
                                                 input logic signed [LonW-1:0] tlon);
    longint lat1, lon1, lat2, lon2, r1, r2, rdlat, rdlon;
    longint s1, c1, s2, c2, sh, ch, sl, cl, sd, cd;
    longint hav, t, range16, bx, by, ang;
    longint unsigned sy, sx, deg;
    range_bearing_t fix;
    lat1 = clip(observer_lat, 64'sd90 <<< AngleFracBits);
    lon1 = clip(observer_lon, 64'sd180 <<< AngleFracBits);
    lat2 = clip(longint'(tlat), 64'sd90 <<< AngleFracBits);
    lon2 = clip(longint'(tlon), 64'sd180 <<< AngleFracBits);
    r1 = deg_to_rad(lat1);
    r2 = deg_to_rad(lat2);
    rdlat = deg_to_rad(lat2 - lat1);
    rdlon = deg_to_rad(lon2 - lon1);
    rotate_sincos(r1, s1, c1);
    rotate_sincos(r2, s2, c2);
    rotate_sincos(rdlat >>> 1, sh, ch);
    rotate_sincos(rdlon >>> 1, sl, cl);
    rotate_sincos(rdlon, sd, cd);

    hav = q30_mul(sh, sh) + q30_mul(q30_mul(c1, c2), q30_mul(sl, sl));
    if (hav < 0) hav = 0;
    if (hav > (64'sd1 <<< 30)) hav = 64'sd1 <<< 30;
    sy = digit_sqrt(longint'(hav) << 30);
    sx = digit_sqrt(((64'sd1 <<< 30) - hav) << 30);
    t = vector_atan2(longint'(sy), longint'(sx));
    if (t < 0) t = 0;
    range16 = (t * 64'sd203872 + (64'sd1 <<< 29)) >>> 30;
    if (range16 > 320240) range16 = 320240;

    bx = q30_mul(sd, c2);
    by = q30_mul(c1, s2) - q30_mul(q30_mul(s1, c2), cd);
    ang = (bx == 0 && by == 0) ? 0 : vector_atan2(bx, by);
    if (ang < 0) ang += TwoPiQ30;
    if (ang < 0) ang = 0;
    if (ang >= TwoPiQ30) ang -= TwoPiQ30;
    if (ang >= TwoPiQ30) ang = 0;
    deg = (longint'(unsigned'(ang)) * 64'd961263669 + (64'd1 << (BearShift - 1)))
          >> BearShift;
    if (deg >= (64'd360 << AngleFracBits)) deg -= 64'd360 << AngleFracBits;
    fix.dist16 = range16[DistW-1:0];
    fix.bear = deg[BearW-1:0];
    return fix;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    range_bearing_t want;
    if (!rst_ni) begin
      observer_lat <= 0;
      observer_lon <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgObsLat)
          observer_lat <= longint'($signed(cfg_wdata_i[LatW-1:0]));
        else if (cfg_index_i == CfgObsLon)
          observer_lon <= longint'($signed(cfg_wdata_i[LonW-1:0]));
      end
      if (target.valid && target.ready)
        expected_fixes.push_back(predict_fix(target.target_latitude,
                                             target.target_longitude));
      if (result.valid && result.ready) begin
        if (expected_fixes.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_fixes.pop_front();
          if (result.distance_sixteenths_km !== want.dist16)
            report_mismatch($sformatf("distance %0d, expected %0d",
                                      result.distance_sixteenths_km, want.dist16));
          if (result.bearing_degrees !== want.bear)
            report_mismatch($sformatf("bearing %0d, expected %0d",
                                      result.bearing_degrees, want.bear));
        end
      end
    end
  end
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gcdb_pkg::*;

  localparam int LatMax = 5898240;
  localparam int LonMax = 11796480;

  logic clk_i, rst_ni, cfg_we_i, cfg_index_i;
  logic [CfgW-1:0] cfg_wdata_i;
  int fail_count, pending;
  bit hold_results, calm;

  gcdb_target_if target ();
  gcdb_result_if result ();

  great_circle_distance_bearing_unit DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .target(target.sink), .result(result.source)
  );

  gcdb_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .target(target), .result(result),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    result.ready = 0;
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        result.ready <= 0;
        repeat (300) @(posedge clk_i);
        hold_results = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        result.ready <= 0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        result.ready <= 1;
      end
    end
  end

  // Called at a rising edge; valid stays high so that requests can follow back to back.
  task automatic send_target(input int lat, input int lon);
    target.valid <= 1;
    target.target_latitude <= lat[LatW-1:0];
    target.target_longitude <= lon[LonW-1:0];
    do @(posedge clk_i); while (!target.ready);
    if (!calm && $urandom_range(0, 3) == 0) begin
      target.valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    target.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_observer(input int lat, input int lon);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_index_i <= CfgObsLat;
    cfg_wdata_i <= CfgW'(lat);
    @(posedge clk_i);
    cfg_index_i <= CfgObsLon;
    cfg_wdata_i <= CfgW'(lon);
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic int pick_lat();
    if ($urandom_range(0, 7) == 0) return $signed(LatW'($urandom));
    return int'($urandom_range(0, 2 * LatMax)) - LatMax;
  endfunction

  function automatic int pick_lon();
    if ($urandom_range(0, 7) == 0) return $signed(LonW'($urandom));
    return int'($urandom_range(0, 2 * LonMax)) - LonMax;
  endfunction

  initial begin
    int obs_lat, obs_lon;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_index_i = CfgObsLat;
    cfg_wdata_i = '0;
    target.valid = 0;
    target.target_latitude = '0;
    target.target_longitude = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;

    // Reset observer at the origin: poles, date line, axes, antipode, clamping.
    send_target(0, 0);
    send_target(LatMax, 0);
    send_target(-LatMax, 0);
    send_target(0, LonMax);
    send_target(0, -LonMax);
    send_target(0, 90 << 16);
    send_target(0, -(90 << 16));
    send_target(45 << 16, 0);
    send_target(-(45 << 16), 0);
    send_target(8388607, 16777215);
    send_target(-8388608, -16777216);
    send_target(LatMax + 1, -LonMax - 1);
    send_target(1, 1);
    send_target(-1, -1);
    send_target(LatMax, LonMax);
    send_target(-LatMax, -LonMax);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: begin obs_lat = LatMax;    obs_lon = LonMax;    end
        1: begin obs_lat = -LatMax;   obs_lon = -LonMax;   end
        2: begin obs_lat = 8388607;   obs_lon = -16777216; end
        3: begin obs_lat = -8388608;  obs_lon = 16777215;  end
        default: begin obs_lat = pick_lat(); obs_lon = pick_lon(); end
      endcase
      set_observer(obs_lat, obs_lon);
      calm = (phase == 5);
      if (phase == 4) begin
        // Identical, antipodal and nearly identical targets for a random observer.
        send_target(obs_lat, obs_lon);
        send_target(-obs_lat, obs_lon + ((obs_lon > 0) ? -LonMax : LonMax));
        send_target(obs_lat, obs_lon + 1);
        hold_results = 1;
      end
      for (int n = 0; n < 130; n++) begin
        send_target(pick_lat(), pick_lon());
        if (n == 60 && phase == 2) drain();
      end
    end

    target.valid <= 0;
    @(posedge clk_i);
    for (int w = 0; w < 20000 && pending != 0; w++) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
